FILE: hw/rtl/ffha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit hole allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int AW            = 10;
    localparam int SW            = 11;
    localparam int MEM_WORDS_DEF = 1024;
    localparam int MAX_HOLES_DEF = 64;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } state_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_SHRINK,
        ACT_REMOVE,
        ACT_MERGE_BOTH,
        ACT_PREV,
        ACT_NEXT,
        ACT_INSERT
    } act_t;

    typedef struct packed {
        act_t          act;
        logic          cmd;
        logic [SW-1:0] size;
        logic [AW-1:0] addr;
        logic [AW-1:0] fend;
    } ctl_t;

    typedef struct packed {
        logic          found;
        logic [AW-1:0] start;
        logic          exact;
        logic          join_prev;
        logic          join_next;
    } carry_t;

endpackage

FILE: hw/rtl/ffha_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_req_if / ffha_rsp_if
// Valid/ready channels for requests and results of the hole allocator.
// ----------------------------------------------------------------------------
interface ffha_req_if;
    import ffha_pkg::*;
    logic          valid;
    logic          ready;
    logic          command;
    logic [SW-1:0] block_size;
    logic [AW-1:0] block_address;

    modport source (output valid, command, block_size, block_address, input ready);
    modport sink   (input valid, command, block_size, block_address, output ready);
endinterface

interface ffha_rsp_if;
    import ffha_pkg::*;
    logic          valid;
    logic          ready;
    logic          granted;
    logic [AW-1:0] address;
    logic [1:0]    status;

    modport source (output valid, granted, address, status, input ready);
    modport sink   (input valid, granted, address, status, output ready);
endinterface

FILE: hw/rtl/ffha_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_cell
// One hole of the table: holds start/end, runs its local compare and passes
// the first-match record to its right neighbor each scan cycle.
// ----------------------------------------------------------------------------
module ffha_cell
    import ffha_pkg::*;
#(
    parameter int            IDX       = 0,
    parameter int            CW        = 7,
    parameter logic [AW-1:0] RST_START = '0,
    parameter logic [AW-1:0] RST_END   = '0
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  ctl_t          ctl,
    input  logic          scan,
    input  logic [CW-1:0] count,
    input  carry_t        carry_in,
    input  logic [AW-1:0] left_start,
    input  logic [AW-1:0] left_end,
    input  logic [AW-1:0] right_start,
    input  logic [AW-1:0] right_end,
    input  logic          right_first,
    output logic [AW-1:0] hole_start,
    output logic [AW-1:0] hole_end,
    output carry_t        carry_out,
    output logic          is_first
);

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] end_reg, end_next;
    carry_t        carry_reg;
    logic          in_range;
    logic [AW:0]   len;
    logic          fit;
    logic          exact;
    logic          match;
    logic          jp;
    logic          jn;
    logic          after;

    always_comb
    begin
        in_range = IDX_C < count;
        len      = {1'b0, end_reg} - {1'b0, start_reg} + (AW+1)'(1);
        exact    = 1'b0;
        if (end_reg >= start_reg)
        begin
            fit   = {1'b0, ctl.size} <= {1'b0, len};
            exact = {1'b0, ctl.size} == {1'b0, len};
        end
        else if ({1'b0, end_reg} + (AW+1)'(1) == {1'b0, start_reg})
        begin
            fit = 1'b0;
        end
        else
        begin
            fit = 1'b1;
        end
        fit = fit && in_range && (ctl.size != '0);
        jn  = in_range && ({1'b0, ctl.fend} + (AW+1)'(1) == {1'b0, start_reg});
        jp  = (IDX > 0) && ({1'b0, left_end} + (AW+1)'(1) == {1'b0, ctl.addr});
        if (ctl.cmd == CMD_ALLOC)
        begin
            match = fit;
        end
        else
        begin
            match = !in_range || (start_reg > ctl.addr);
        end
    end

    assign after     = carry_reg.found;
    assign is_first  = match && !carry_reg.found;
    assign carry_out = carry_reg.found ? carry_reg : carry_t'{found: match, start: start_reg,
                                                              exact: exact, join_prev: jp,
                                                              join_next: jn};
    assign hole_start = start_reg;
    assign hole_end   = end_reg;

    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        case (ctl.act)
            ACT_SHRINK:
            begin
                if (is_first)
                begin
                    start_next = AW'({1'b0, start_reg} + ctl.size);
                end
            end
            ACT_REMOVE:
            begin
                if (is_first || after)
                begin
                    start_next = right_start;
                    end_next   = right_end;
                end
            end
            ACT_MERGE_BOTH:
            begin
                if (right_first)
                begin
                    end_next = right_end;
                end
                if (is_first || after)
                begin
                    start_next = right_start;
                    end_next   = right_end;
                end
            end
            ACT_PREV:
            begin
                if (right_first)
                begin
                    end_next = ctl.fend;
                end
            end
            ACT_NEXT:
            begin
                if (is_first)
                begin
                    start_next = ctl.addr;
                end
            end
            ACT_INSERT:
            begin
                if (is_first)
                begin
                    start_next = ctl.addr;
                    end_next   = ctl.fend;
                end
                else if (after)
                begin
                    start_next = left_start;
                    end_next   = left_end;
                end
            end
            default:
            begin
                start_next = start_reg;
                end_next   = end_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= RST_START;
            end_reg   <= RST_END;
            carry_reg <= '0;
        end
        else
        begin
            start_reg <= start_next;
            end_reg   <= end_next;
            if (scan)
            begin
                carry_reg <= carry_in;
            end
        end
    end

endmodule

FILE: hw/rtl/first_fit_hole_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_hole_allocator
// Address-sorted free-hole table with first-fit allocate and coalescing free.
// ----------------------------------------------------------------------------
// A result is ready once its request has passed the scan and apply states:
// the first-match record walks the chain of hole cells one cell per cycle
// in the scan, then all cells shift or update together in the apply state,
// which waits while a result stalls at the output. One request is in work
// at a time; a finished result waits in the output register while the next
// request is taken. No clearing pass: the table is ready right after reset.
module first_fit_hole_allocator
    import ffha_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF,
    parameter int MAX_HOLES = MAX_HOLES_DEF
)
(
    input logic  clk,
    input logic  rst_n,
    ffha_req_if.sink   req,
    ffha_rsp_if.source rsp
);

    localparam int CW = $clog2(MAX_HOLES + 1);
    localparam logic [CW-1:0] FULL_C = CW'(MAX_HOLES);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cyc_reg, cyc_next;
    logic          cmd_reg;
    logic [SW-1:0] size_reg;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] fend_reg;
    logic          out_valid_reg;
    logic          granted_reg;
    logic [AW-1:0] address_reg;
    logic [1:0]    status_reg;

    logic [AW-1:0] hs [MAX_HOLES];
    logic [AW-1:0] he [MAX_HOLES];
    carry_t        co [MAX_HOLES];
    logic          first [MAX_HOLES];

    ctl_t          ctl;
    act_t          act;
    logic          apply_fire;
    logic          res_granted;
    logic [AW-1:0] res_address;
    logic [1:0]    res_status;
    carry_t        fin;
    logic          jp;
    logic          jn;
    logic          bypass;
    logic [AW+1:0] fend_sum;
    logic [AW-1:0] fend_calc;

    assign req.ready  = state_reg == S_IDLE;
    assign apply_fire = (state_reg == S_APPLY) && (!out_valid_reg || rsp.ready);

    assign fend_sum  = {2'b00, req.block_address} + {1'b0, req.block_size} - (AW+2)'(1);
    assign fend_calc = (32'(fend_sum) > 32'(MEM_WORDS - 1)) ? AW'(MEM_WORDS - 1)
                                                           : fend_sum[AW-1:0];

    assign ctl = '{act: apply_fire ? act : ACT_NONE, cmd: cmd_reg, size: size_reg,
                   addr: addr_reg, fend: fend_reg};

    genvar k;
    generate
        for (k = 0; k < MAX_HOLES; k++)
        begin : g_cell
            carry_t        cin;
            logic [AW-1:0] ls, le, rs, re;
            logic          rf;
            if (k == 0)
            begin : g_l0
                assign cin = '0;
                assign ls  = '0;
                assign le  = '0;
            end
            else
            begin : g_ln
                assign cin = co[k-1];
                assign ls  = hs[k-1];
                assign le  = he[k-1];
            end
            if (k == MAX_HOLES - 1)
            begin : g_rl
                assign rs = hs[k];
                assign re = he[k];
                assign rf = !co[k].found;
            end
            else
            begin : g_rn
                assign rs = hs[k+1];
                assign re = he[k+1];
                assign rf = first[k+1];
            end
            ffha_cell #(
                .IDX       (k),
                .CW        (CW),
                .RST_START ('0),
                .RST_END   ((k == 0) ? AW'(MEM_WORDS - 1) : '0)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .scan        (state_reg == S_SCAN),
                .count       (count_reg),
                .carry_in    (cin),
                .left_start  (ls),
                .left_end    (le),
                .right_start (rs),
                .right_end   (re),
                .right_first (rf),
                .hole_start  (hs[k]),
                .hole_end    (he[k]),
                .carry_out   (co[k]),
                .is_first    (first[k])
            );
        end
    endgenerate

    assign fin    = co[MAX_HOLES-1];
    assign bypass = (size_reg == '0) || (32'(addr_reg) >= 32'(MEM_WORDS));
    assign jp     = fin.found ? fin.join_prev
                              : ({1'b0, he[MAX_HOLES-1]} + (AW+1)'(1) == {1'b0, addr_reg});
    assign jn     = fin.found && fin.join_next;

    always_comb
    begin
        act         = ACT_NONE;
        res_granted = 1'b1;
        res_address = '0;
        res_status  = ST_OK;
        count_next  = count_reg;
        if (cmd_reg == CMD_ALLOC)
        begin
            if (fin.found)
            begin
                act         = fin.exact ? ACT_REMOVE : ACT_SHRINK;
                res_address = fin.start;
                if (fin.exact)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            else
            begin
                res_granted = 1'b0;
                res_status  = ST_NOFIT;
            end
        end
        else if (!bypass)
        begin
            if (jp && jn)
            begin
                act        = ACT_MERGE_BOTH;
                count_next = count_reg - CW'(1);
            end
            else if (jp)
            begin
                act = ACT_PREV;
            end
            else if (jn)
            begin
                act = ACT_NEXT;
            end
            else if (count_reg >= FULL_C)
            begin
                res_granted = 1'b0;
                res_status  = ST_FULL;
            end
            else
            begin
                act        = ACT_INSERT;
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (cyc_reg == FULL_C - CW'(1))
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (apply_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cyc_next = '0;
        case (state_reg)
            S_SCAN:
            begin
                cyc_next = cyc_reg + CW'(1);
            end
            default:
            begin
                cyc_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CW'(1);
            cyc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cyc_reg   <= cyc_next;
            if (apply_fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg  <= req.command;
            size_reg <= req.block_size;
            addr_reg <= req.block_address;
            fend_reg <= fend_calc;
        end
        if (apply_fire)
        begin
            granted_reg <= res_granted;
            address_reg <= res_address;
            status_reg  <= res_status;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.granted = granted_reg;
    assign rsp.address = address_reg;
    assign rsp.status  = status_reg;

endmodule

FILE: hw/rtl/ffha_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the hole allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffha_checker
    import ffha_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input logic          granted,
    input logic [AW-1:0] address,
    input logic [1:0]    status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in work");

    a_grant_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (granted == (status == ST_OK)))
        else $error("granted and status disagree");

    a_refused_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !granted |-> address == '0 &&
        (status == ST_NOFIT || status == ST_FULL))
        else $error("bad refused result");

endmodule

bind first_fit_hole_allocator ffha_checker u_ffha_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .granted   (rsp.granted),
    .address   (rsp.address),
    .status    (rsp.status)
);

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the first-fit hole allocator against a predictor of its hole table:
// directed corner requests, table-full pressure, then random alloc/free
// traffic, partly under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import ffha_pkg::*;

    localparam int MEMW  = 1024;
    localparam int HOLES = 64;

    typedef struct packed {
        logic          granted;
        logic [AW-1:0] address;
        logic [1:0]    status;
    } grant_t;

    typedef struct {
        int unsigned lo;
        int unsigned sz;
    } span_t;

    logic clk;
    logic rst_n;

    ffha_req_if req ();
    ffha_rsp_if rsp ();

    first_fit_hole_allocator #(.MEM_WORDS(MEMW), .MAX_HOLES(HOLES)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    int unsigned hole_lo [HOLES];
    int unsigned hole_hi [HOLES];
    int unsigned hole_num;
    grant_t      pending_grants [$];
    span_t       owned [$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic drop_hole(input int unsigned pos);
        for (int unsigned k = pos; k + 1 < hole_num; k++)
        begin
            hole_lo[k] = hole_lo[k + 1];
            hole_hi[k] = hole_hi[k + 1];
        end
        hole_num--;
    endtask

    task automatic predict_alloc(input int unsigned size, output grant_t g);
        int unsigned len;
        g = '{granted: 1'b0, address: '0, status: ST_NOFIT};
        if (size == 0)
            return;
        for (int unsigned i = 0; i < hole_num; i++)
        begin
            len = hole_hi[i] - hole_lo[i] + 1;
            if (size <= len)
            begin
                g = '{granted: 1'b1, address: hole_lo[i][AW-1:0], status: ST_OK};
                if (size < len)
                    hole_lo[i] += size;
                else
                    drop_hole(i);
                return;
            end
        end
    endtask

    task automatic predict_free(input int unsigned size, input int unsigned a, output grant_t g);
        int unsigned last;
        int unsigned pos;
        bit          jp;
        bit          jn;
        g = '{granted: 1'b1, address: '0, status: ST_OK};
        if (size == 0 || a >= MEMW)
            return;
        last = a + size - 1;
        if (last > MEMW - 1)
            last = MEMW - 1;
        pos = 0;
        while (pos < hole_num && hole_lo[pos] <= a)
            pos++;
        jp = pos > 0 && hole_hi[pos - 1] + 1 == a;
        jn = pos < hole_num && last + 1 == hole_lo[pos];
        if (jp && jn)
        begin
            hole_hi[pos - 1] = hole_hi[pos];
            drop_hole(pos);
        end
        else if (jp)
            hole_hi[pos - 1] = last;
        else if (jn)
            hole_lo[pos] = a;
        else if (hole_num >= HOLES)
            g = '{granted: 1'b0, address: '0, status: ST_FULL};
        else
        begin
            for (int unsigned k = hole_num; k > pos; k--)
            begin
                hole_lo[k] = hole_lo[k - 1];
                hole_hi[k] = hole_hi[k - 1];
            end
            hole_lo[pos] = a;
            hole_hi[pos] = last;
            hole_num++;
        end
    endtask

    task automatic send_request(input logic cmd, input int unsigned size, input int unsigned a);
        grant_t g;
        @(negedge clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(negedge clk);
        req.valid         <= 1'b1;
        req.command       <= cmd;
        req.block_size    <= size[SW-1:0];
        req.block_address <= a[AW-1:0];
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (cmd == CMD_ALLOC)
        begin
            predict_alloc(size[SW-1:0], g);
            if (g.granted)
                owned.push_back('{lo: g.address, sz: size});
        end
        else
            predict_free(size[SW-1:0], a[AW-1:0], g);
        pending_grants.push_back(g);
        @(negedge clk);
        req.valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp.ready   <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            rsp.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_grants.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat g=%0d a=%0d s=%0d",
                             rsp.granted, rsp.address, rsp.status);
            end
            else
            begin
                want = pending_grants.pop_front();
                if (rsp.granted !== want.granted || rsp.address !== want.address ||
                    rsp.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp g=%0d a=%0d s=%0d got g=%0d a=%0d s=%0d",
                                 want.granted, want.address, want.status,
                                 rsp.granted, rsp.address, rsp.status);
                end
            end
        end
    end

    task automatic release_owned(input int unsigned idx);
        span_t b;
        b = owned[idx];
        owned.delete(idx);
        send_request(CMD_FREE, b.sz, b.lo);
    endtask

    task automatic drain();
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (3 * HOLES)
            @(posedge clk);
    endtask

    task automatic test_corners();
        send_request(CMD_ALLOC, 0, 0);
        send_request(CMD_FREE, 0, 5);
        send_request(CMD_ALLOC, 1024, 1023);
        send_request(CMD_ALLOC, 1, 0);
        send_request(CMD_FREE, 5, 1023);
        send_request(CMD_FREE, 2047, 0);
        send_request(CMD_ALLOC, 2047, 0);
        send_request(CMD_ALLOC, 100, 0);
        send_request(CMD_ALLOC, 100, 0);
        send_request(CMD_ALLOC, 100, 0);
        send_request(CMD_FREE, 100, 100);
        send_request(CMD_FREE, 100, 0);
        send_request(CMD_FREE, 100, 200);
        send_request(CMD_ALLOC, 724, 0);
        send_request(CMD_ALLOC, 300, 0);
        send_request(CMD_ALLOC, 1, 0);
        send_request(CMD_FREE, 10, 512);
        send_request(CMD_FREE, 10, 522);
        send_request(CMD_FREE, 10, 502);
        send_request(CMD_FREE, 1024, 0);
        owned.delete();
        drain();
    endtask

    task automatic test_table_full();
        hold_cycles = 2000;
        for (int i = 0; i < HOLES + 2; i++)
            send_request(CMD_FREE, 1, 2 * i);
        drain();
        send_request(CMD_ALLOC, 1024, 0);
        send_request(CMD_FREE, 1024, 0);
        drain();
    endtask

    task automatic test_random();
        int unsigned pick;
        for (int n = 0; n < 300; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_request(CMD_ALLOC,
                             ($urandom_range(9) == 0) ? $urandom_range(2047) :
                                                        $urandom_range(1, 64), $urandom);
            else if (pick < 90 && owned.size() != 0)
                release_owned($urandom_range(owned.size() - 1));
            else if (pick < 95)
                send_request(CMD_FREE, $urandom_range(2047), $urandom_range(1023));
            else
                send_request(CMD_FREE, 0, $urandom_range(1023));
            if (pick >= 90)
                owned.delete();
            if (pick >= 90 && pick < 95)
            begin
                drain();
                send_request(CMD_FREE, 1024, 0);
            end
            if (n % 100 == 99)
            begin
                if (send_idle_pct == 12)
                begin
                    send_idle_pct = 79;
                    recv_idle_pct = 12;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            end
        end
        drain();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        req.valid         = 1'b0;
        req.command       = CMD_ALLOC;
        req.block_size    = '0;
        req.block_address = '0;
        rsp.ready         = 1'b0;
        mismatches        = 0;
        hold_cycles       = 0;
        send_idle_pct     = 12;
        recv_idle_pct     = 79;
        hole_lo[0]        = 0;
        hole_hi[0]        = MEMW - 1;
        hole_num          = 1;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_corners();
        test_table_full();
        test_random();
        if (mismatches == 0 && pending_grants.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("testbench: errors");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_if.sv
hw/rtl/ffha_cell.sv
hw/rtl/first_fit_hole_allocator.sv
hw/rtl/ffha_checker.sv
dv/testbench.sv
